FILE: rtl/ljpe_pkg.sv
// Package with the shared constants, word types and codes of the Lennard-Jones energy block.
`timescale 1ns / 1ps
package ljpe_pkg;
	localparam int MAX_ATOMS = 32;
	localparam int ADDR_W    = $clog2(MAX_ATOMS);
	localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
	localparam int COORD_W   = 22;
	localparam int SIG_W     = 20;
	localparam int ENERGY_W  = 48;
	localparam int CFG_IDX_W = 3;

	typedef struct packed {
		logic [COORD_W-1:0] atom_x;
		logic [COORD_W-1:0] atom_y;
		logic [COORD_W-1:0] atom_z;
		logic               last_atom;
	} atom_word_t;

	typedef struct packed {
		logic signed [ENERGY_W-1:0] energy_sum;
		logic                       saturated;
	} result_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] box_x;
		logic [COORD_W-1:0] box_y;
		logic [COORD_W-1:0] box_z;
		logic [SIG_W-1:0]   sigma;
		logic [SIG_W-1:0]   eps;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               store;
		logic [ADDR_W-1:0]  addr;
		logic [CNT_W-1:0]   cnt;
		logic               last;
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOX_X = 3'd0,
		CFG_BOX_Y = 3'd1,
		CFG_BOX_Z = 3'd2,
		CFG_SIGMA = 3'd3,
		CFG_EPS   = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RD,
		ST_DIFF,
		ST_WRAP1,
		ST_WRAP2,
		ST_MUL,
		ST_POST,
		ST_DIV,
		ST_QCHK,
		ST_BIG,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MO_SQ,
		MO_SIG,
		MO_Q2,
		MO_Q3,
		MO_S12,
		MO_EPS
	} mul_op_t;

	localparam logic signed [48:0] TERM_MAX = 49'sd140737488355327;
	localparam logic signed [49:0] SUM_MAX  = 50'sd140737488355327;
	localparam logic signed [49:0] SUM_MIN  = -50'sd140737488355328;
endpackage

FILE: rtl/ljpe_front.sv
// Front end: accepts atom words, counts the set and classifies each word for the back end.
`timescale 1ns / 1ps
module ljpe_front import ljpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  atom_word_t atom,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);
	logic [CNT_W-1:0] count_q;
	logic             store;
	logic             accept;

	assign accept = push && !q_full;
	assign full   = q_full;
	assign q_push = accept;
	assign store  = count_q < CNT_W'(MAX_ATOMS);

	always_comb begin
		q_cmd.x     = atom.atom_x;
		q_cmd.y     = atom.atom_y;
		q_cmd.z     = atom.atom_z;
		q_cmd.store = store;
		q_cmd.addr  = count_q[ADDR_W-1:0];
		q_cmd.cnt   = store ? count_q + CNT_W'(1) : count_q;
		q_cmd.last  = atom.last_atom;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (atom.last_atom) begin
				count_q <= '0;
			end else if (store) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end
endmodule

FILE: rtl/ljpe_cmd_fifo.sv
// Two-entry queue of classified words between the front end and the back end.
`timescale 1ns / 1ps
module ljpe_cmd_fifo import ljpe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_data,
	output logic q_full,
	input  logic rd,
	output cmd_t rd_data,
	output logic q_empty
);
	cmd_t       mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign q_full  = count_q == 2'd2;
	assign q_empty = count_q == 2'd0;
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end
endmodule

FILE: rtl/ljpe_back.sv
// Back end: coordinate store, pair sequencer, shared multiplier, divider and energy sum.
`timescale 1ns / 1ps
module ljpe_back import ljpe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  logic         cmd_empty,
	output logic         cmd_pop,
	input  cfg_t         cfg,
	output result_word_t result,
	output logic         empty,
	input  logic         pop
);
	logic [COORD_W-1:0] mem_x [MAX_ATOMS];
	logic [COORD_W-1:0] mem_y [MAX_ATOMS];
	logic [COORD_W-1:0] mem_z [MAX_ATOMS];
	logic [COORD_W-1:0] xi_q, yi_q, zi_q, xj_q, yj_q, zj_q;

	state_t            state_q, state_d;
	mul_op_t           op_q;
	logic [ADDR_W-1:0] i_q, j_q;
	logic [CNT_W-1:0]  n_q;
	logic [1:0]        axis_q;
	logic signed [23:0] d_q;
	logic [45:0]       r2_q;
	logic [63:0]       ma_q, mb_q;
	logic [63:0]       pp_q;
	logic [1:0]        psel_q;
	logic [127:0]      prod_q;
	logic [2:0]        mcnt_q;
	logic [63:0]       quo_q, dvd_q;
	logic [45:0]       rem_q;
	logic [5:0]        dcnt_q;
	logic [62:0]       q_q, s6_q;
	logic              pos_q;
	logic signed [48:0] term_q;
	logic              term_sat_q;
	logic signed [47:0] acc_q;
	logic              sat_q;
	logic              out_valid_q;
	result_word_t      result_q;

	logic              out_load;
	logic [COORD_W-1:0] ca, cb, cbox;
	logic signed [24:0] d2, boxs;
	logic signed [23:0] box24, dw, dabs;
	logic [31:0]       a_part, b_part;
	logic [127:0]      pp_ext;
	logic [46:0]       rem_sh;
	logic              rem_ge;
	logic              big24, big16;
	logic [62:0]       r24, mag;
	logic [62:0]       s12_diff;
	logic              s12_pos;
	logic signed [49:0] sum;
	logic              j_more, i_more;

	always_comb begin
		unique case (axis_q)
			2'd0: begin
				ca = xi_q; cb = xj_q; cbox = cfg.box_x;
			end
			2'd1: begin
				ca = yi_q; cb = yj_q; cbox = cfg.box_y;
			end
			default: begin
				ca = zi_q; cb = zj_q; cbox = cfg.box_z;
			end
		endcase
		box24  = $signed({2'b00, cbox});
		d2     = $signed({d_q, 1'b0});
		boxs   = $signed({3'b000, cbox});
		dw     = (d2 > boxs) ? d_q - box24 : d_q;
		dabs   = dw[23] ? -dw : dw;
		a_part = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		b_part = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		unique case (psel_q)
			2'd0:    pp_ext = {64'b0, pp_q};
			2'd3:    pp_ext = {pp_q, 64'b0};
			default: pp_ext = {32'b0, pp_q, 32'b0};
		endcase
		rem_sh   = {rem_q, dvd_q[63]};
		rem_ge   = rem_sh >= {1'b0, r2_q};
		big24    = |prod_q[127:87];
		big16    = |prod_q[127:79];
		r24      = prod_q[86:24];
		mag      = prod_q[78:16];
		s12_pos  = r24 >= s6_q;
		s12_diff = s12_pos ? r24 - s6_q : s6_q - r24;
		sum      = 50'(acc_q) + 50'(term_q);
		j_more   = ({1'b0, j_q} + CNT_W'(1)) < n_q;
		i_more   = ({1'b0, i_q} + CNT_W'(2)) < n_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && cmd.last) begin
					state_d = (cmd.cnt < CNT_W'(2)) ? ST_OUT : ST_LOAD;
				end
			end
			ST_LOAD:  state_d = ST_RD;
			ST_RD:    state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_WRAP1;
			ST_WRAP1: state_d = ST_WRAP2;
			ST_WRAP2: state_d = ST_MUL;
			ST_MUL: begin
				if (mcnt_q == 3'd4) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				unique case (op_q)
					MO_SQ:  state_d = (axis_q == 2'd2) ? ST_MUL : ST_DIFF;
					MO_SIG: state_d = (r2_q == '0) ? ST_ACC : ST_DIV;
					MO_Q2, MO_Q3, MO_S12: state_d = big24 ? ST_BIG : ST_MUL;
					default: state_d = ST_ACC;
				endcase
			end
			ST_DIV: begin
				if (dcnt_q == 6'd63) begin
					state_d = ST_QCHK;
				end
			end
			ST_QCHK: state_d = quo_q[63] ? ST_BIG : ST_MUL;
			ST_BIG:  state_d = ST_ACC;
			ST_ACC:  state_d = (j_more || i_more) ? ST_LOAD : ST_OUT;
			ST_OUT: begin
				if (!out_valid_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
		out_load = (state_q == ST_OUT) && !out_valid_q;
		empty    = !out_valid_q;
		result   = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.store) begin
			mem_x[cmd.addr] <= cmd.x;
			mem_y[cmd.addr] <= cmd.y;
			mem_z[cmd.addr] <= cmd.z;
		end
		xi_q <= mem_x[i_q];
		yi_q <= mem_y[i_q];
		zi_q <= mem_z[i_q];
		xj_q <= mem_x[j_q];
		yj_q <= mem_y[j_q];
		zj_q <= mem_z[j_q];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.energy_sum <= acc_q;
			result_q.saturated  <= sat_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_pop && cmd.last) begin
					n_q   <= cmd.cnt;
					i_q   <= '0;
					j_q   <= ADDR_W'(1);
					acc_q <= '0;
					sat_q <= 1'b0;
				end
			end
			ST_RD: begin
				axis_q <= 2'd0;
				r2_q   <= '0;
			end
			ST_DIFF: begin
				d_q <= $signed({2'b00, cb}) - $signed({2'b00, ca});
			end
			ST_WRAP1: begin
				if (d2 < -boxs) begin
					d_q <= d_q + box24;
				end
			end
			ST_WRAP2: begin
				ma_q   <= {40'b0, dabs};
				mb_q   <= {40'b0, dabs};
				op_q   <= MO_SQ;
				prod_q <= '0;
				mcnt_q <= 3'd0;
			end
			ST_MUL: begin
				if (mcnt_q != 3'd4) begin
					pp_q   <= a_part * b_part;
					psel_q <= mcnt_q[1:0];
				end
				if (mcnt_q != 3'd0) begin
					prod_q <= prod_q + pp_ext;
				end
				mcnt_q <= mcnt_q + 3'd1;
			end
			ST_POST: begin
				prod_q <= '0;
				mcnt_q <= 3'd0;
				unique case (op_q)
					MO_SQ: begin
						r2_q   <= r2_q + prod_q[45:0];
						axis_q <= axis_q + 2'd1;
						ma_q   <= {44'b0, cfg.sigma};
						mb_q   <= {44'b0, cfg.sigma};
						op_q   <= MO_SIG;
					end
					MO_SIG: begin
						term_q     <= TERM_MAX;
						term_sat_q <= 1'b1;
						dvd_q      <= {prod_q[39:0], 24'b0};
						rem_q      <= '0;
						quo_q      <= '0;
						dcnt_q     <= '0;
					end
					MO_Q2: begin
						ma_q <= {1'b0, r24};
						mb_q <= {1'b0, q_q};
						op_q <= MO_Q3;
					end
					MO_Q3: begin
						s6_q <= r24;
						ma_q <= {1'b0, r24};
						mb_q <= {1'b0, r24};
						op_q <= MO_S12;
					end
					MO_S12: begin
						pos_q <= s12_pos;
						ma_q  <= {1'b0, s12_diff};
						mb_q  <= {44'b0, cfg.eps};
						op_q  <= MO_EPS;
					end
					default: begin
						if (pos_q) begin
							if (big16 || (|mag[62:45])) begin
								term_q     <= TERM_MAX;
								term_sat_q <= 1'b1;
							end else begin
								term_q     <= $signed({2'b00, mag[44:0], 2'b00});
								term_sat_q <= 1'b0;
							end
						end else begin
							term_q     <= -$signed({2'b00, mag[44:0], 2'b00});
							term_sat_q <= 1'b0;
						end
					end
				endcase
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? 46'(rem_sh - {1'b0, r2_q}) : rem_sh[45:0];
				quo_q  <= {quo_q[62:0], rem_ge};
				dvd_q  <= {dvd_q[62:0], 1'b0};
				dcnt_q <= dcnt_q + 6'd1;
			end
			ST_QCHK: begin
				q_q    <= quo_q[62:0];
				ma_q   <= quo_q;
				mb_q   <= quo_q;
				op_q   <= MO_Q2;
				prod_q <= '0;
				mcnt_q <= 3'd0;
			end
			ST_BIG: begin
				term_q     <= (cfg.eps == '0) ? 49'sd0 : TERM_MAX;
				term_sat_q <= cfg.eps != '0;
			end
			ST_ACC: begin
				if (sum > SUM_MAX) begin
					acc_q <= SUM_MAX[47:0];
					sat_q <= 1'b1;
				end else if (sum < SUM_MIN) begin
					acc_q <= SUM_MIN[47:0];
					sat_q <= 1'b1;
				end else begin
					acc_q <= sum[47:0];
					sat_q <= sat_q || term_sat_q;
				end
				if (j_more) begin
					j_q <= j_q + ADDR_W'(1);
				end else if (i_more) begin
					i_q <= i_q + ADDR_W'(1);
					j_q <= i_q + ADDR_W'(2);
				end
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (i_q < j_q) && ({1'b0, j_q} < n_q))
		else $error("Pair indices out of order or beyond the stored set.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < r2_q))
		else $error("Divider remainder is not below the divisor.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (term_q <= TERM_MAX) && (term_q > -49'sd1073741824))
		else $error("Pair term outside its possible range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("Result word loaded outside the output state.");
endmodule

FILE: rtl/lennard_jones_pair_energy.sv
// Top level of the Lennard-Jones 12-6 periodic pair energy block with its register file.
//
// Usage: atom words enter through a queue-like port (push, full, atom) and are stored in
// arrival order, up to 32 atoms; further atoms are dropped. A word with last_atom set ends
// the set: the block then sums the pair energy over every unordered pair of stored atoms
// and offers one result word (energy_sum, saturated) on a queue-like output
// (empty, pop, result). The set is then cleared for the next one.
// After the last atom, each pair is worked out by the bit-serial divider and the shared
// 32x32 multiplier that builds every wide product from four partial products. A
// two-word queue lies between the front end and the back end, so atoms of the next set
// can be accepted while a sum runs until the queue fills, at which point full stays high.
// If the receiver does not pop, the result word stays on the output while the back end
// goes on with the next set; it waits once that set's result is ready, and the front end
// keeps accepting until the queue is full.
// Reset clears the count, the queue, the result valid flag and the registers to their
// defaults; the coordinate store is not cleared and needs no clearing pass. The user must write
// registers through cfg_we, cfg_index and cfg_data only while the block is idle (unchecked).
`timescale 1ns / 1ps
module lennard_jones_pair_energy import ljpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  atom_word_t           atom,
	output logic                 empty,
	input  logic                 pop,
	output result_word_t         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);
	cfg_t cfg_q;
	cmd_t f_cmd, b_cmd;
	logic f_push, q_full, q_empty, b_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_x <= COORD_W'(983040);
			cfg_q.box_y <= COORD_W'(983040);
			cfg_q.box_z <= COORD_W'(983040);
			cfg_q.sigma <= SIG_W'(237503);
			cfg_q.eps   <= SIG_W'(20775);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_X: cfg_q.box_x <= cfg_data;
				CFG_BOX_Y: cfg_q.box_y <= cfg_data;
				CFG_BOX_Z: cfg_q.box_z <= cfg_data;
				CFG_SIGMA: cfg_q.sigma <= cfg_data[SIG_W-1:0];
				CFG_EPS:   cfg_q.eps   <= cfg_data[SIG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ljpe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.atom   (atom),
		.q_full (q_full),
		.q_push (f_push),
		.q_cmd  (f_cmd)
	);

	ljpe_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_push),
		.wr_data (f_cmd),
		.q_full  (q_full),
		.rd      (b_pop),
		.rd_data (b_cmd),
		.q_empty (q_empty)
	);

	ljpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (b_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (b_pop),
		.cfg       (cfg_q),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);
endmodule

FILE: tb/sv/ljpe_energy_checker.sv
// Checker that predicts and compares the result words of the Lennard-Jones energy block.
`timescale 1ns / 1ps
module ljpe_energy_checker import ljpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  atom_word_t           atom,
	input  logic                 empty,
	input  logic                 pop,
	input  result_word_t         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	output int                   errors,
	output int                   pending
);
	localparam longint E_MAX = 64'sd140737488355327;
	localparam longint E_MIN = -64'sd140737488355328;
	localparam logic [63:0] CAP = 64'h7FFF_FFFF_FFFF_FFFF;

	logic [COORD_W-1:0] box_x, box_y, box_z;
	logic [SIG_W-1:0]   sigma, eps;
	logic [COORD_W-1:0] pos_x [MAX_ATOMS];
	logic [COORD_W-1:0] pos_y [MAX_ATOMS];
	logic [COORD_W-1:0] pos_z [MAX_ATOMS];
	int                 n_stored;
	result_word_t       energy_q [$];

	function automatic logic [63:0] sq_delta(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
		logic [COORD_W-1:0] box);
		longint d;
		longint bx;
		d = longint'(b) - longint'(a);
		bx = longint'(box);
		if (2 * d < -bx) d += bx;
		if (2 * d > bx) d -= bx;
		if (d < 0) d = -d;
		return d * d;
	endfunction

	function automatic logic [63:0] scaled_mul(logic [63:0] a, logic [63:0] b, int sh,
		inout bit big);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		if (p[127:63] != 0) begin
			big = 1;
			return CAP;
		end
		return p[63:0];
	endfunction

	function automatic longint pair_energy(int i, int j, inout bit sat);
		logic [63:0] r2, sig2, q, s6, s12, mag;
		bit big;
		big = 0;
		r2 = sq_delta(pos_x[i], pos_x[j], box_x) + sq_delta(pos_y[i], pos_y[j], box_y)
			+ sq_delta(pos_z[i], pos_z[j], box_z);
		sig2 = {44'd0, sigma} * {44'd0, sigma};
		if (r2 == 0) begin
			sat = 1;
			return E_MAX;
		end
		q = (sig2 << 24) / r2;
		s6 = 0;
		s12 = 0;
		if (q[63]) begin
			big = 1;
		end else begin
			s6 = scaled_mul(scaled_mul(q, q, 24, big), q, 24, big);
			s12 = scaled_mul(s6, s6, 24, big);
		end
		if (big) begin
			if (eps == 0) return 0;
			sat = 1;
			return E_MAX;
		end
		if (s12 >= s6) begin
			mag = scaled_mul(s12 - s6, {44'd0, eps}, 16, big);
			if (big || mag > (E_MAX >> 2)) begin
				sat = 1;
				return E_MAX;
			end
			return longint'(mag << 2);
		end
		mag = scaled_mul(s6 - s12, {44'd0, eps}, 16, big);
		return -longint'(mag << 2);
	endfunction

	function automatic result_word_t set_energy();
		result_word_t r;
		longint acc, s;
		bit sat;
		acc = 0;
		sat = 0;
		for (int i = 0; i + 1 < n_stored; i++) begin
			for (int j = i + 1; j < n_stored; j++) begin
				s = acc + pair_energy(i, j, sat);
				if (s > E_MAX) begin
					s = E_MAX;
					sat = 1;
				end
				if (s < E_MIN) begin
					s = E_MIN;
					sat = 1;
				end
				acc = s;
			end
		end
		r.energy_sum = acc[ENERGY_W-1:0];
		r.saturated = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			box_x = 983040;
			box_y = 983040;
			box_z = 983040;
			sigma = 237503;
			eps = 20775;
			n_stored = 0;
			errors = 0;
			energy_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BOX_X: box_x = cfg_data;
					CFG_BOX_Y: box_y = cfg_data;
					CFG_BOX_Z: box_z = cfg_data;
					CFG_SIGMA: sigma = cfg_data[SIG_W-1:0];
					CFG_EPS:   eps = cfg_data[SIG_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (energy_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word energy=%0d sat=%0b", $time,
						result.energy_sum, result.saturated);
				end else begin
					want = energy_q.pop_front();
					if (result.energy_sum !== want.energy_sum) begin
						errors++;
						$display("%0t: energy_sum expected %0d, got %0d", $time,
							want.energy_sum, result.energy_sum);
					end
					if (result.saturated !== want.saturated) begin
						errors++;
						$display("%0t: saturated expected %0b, got %0b", $time,
							want.saturated, result.saturated);
					end
				end
			end
			if (push && !full) begin
				if (n_stored < MAX_ATOMS) begin
					pos_x[n_stored] = atom.atom_x;
					pos_y[n_stored] = atom.atom_y;
					pos_z[n_stored] = atom.atom_z;
					n_stored++;
				end
				if (atom.last_atom) begin
					energy_q.push_back(set_energy());
					n_stored = 0;
				end
			end
			pending = energy_q.size();
		end
	end
endmodule

FILE: tb/sv/lennard_jones_pair_energy_test.sv
// Testbench top that drives atom sets and register settings into the Lennard-Jones energy block.
`timescale 1ns / 1ps
module lennard_jones_pair_energy_test;
	import ljpe_pkg::*;

	localparam logic [COORD_W-1:0] C_MAX = '1;
	localparam logic [COORD_W-1:0] BOX_DEF = 983040;
	localparam int LIMIT = 4000000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 push = 0;
	logic                 full;
	atom_word_t           atom = '0;
	logic                 empty;
	logic                 pop = 0;
	result_word_t         result;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data = '0;
	int                   errors;
	int                   pending;
	int                   cycles = 0;
	int                   burst_left = 0;
	int                   n_sent = 0;
	bit                   hold_req = 0;
	logic [COORD_W-1:0]   cur_box = BOX_DEF;

	always #1 clk = ~clk;

	lennard_jones_pair_energy u_top (.*);

	ljpe_energy_checker u_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("lennard_jones_pair_energy_test: done, errors");
			$finish;
		end
	end

	initial begin
		int mode;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				pop <= 0;
				repeat (3000) @(negedge clk);
			end
			if (cycles % 300 == 0) mode = $urandom_range(2, 0);
			case (mode)
				0: pop <= 1;
				1: pop <= ($urandom_range(1, 0) == 1);
				default: pop <= ($urandom_range(9, 0) == 0);
			endcase
		end
	end

	task automatic send(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
		logic last);
		if (burst_left == 0) begin
			push <= 0;
			repeat ($urandom_range(3) == 0 ? 0 : $urandom_range(12, 1)) @(negedge clk);
			burst_left = $urandom_range(20, 1);
		end
		push <= 1;
		atom <= '{atom_x: x, atom_y: y, atom_z: z, last_atom: last};
		do @(posedge clk); while (full);
		@(negedge clk);
		burst_left--;
		n_sent++;
	endtask

	task automatic settle();
		push <= 0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(int style, logic [COORD_W-1:0] base);
		case (style)
			0: return $urandom_range(C_MAX, 0);
			1: return $urandom_range(cur_box - 1, 0);
			default: return base + $urandom_range(393216, 0);
		endcase
	endfunction

	task automatic random_set(int n);
		int style;
		logic [COORD_W-1:0] bx, by, bz;
		style = $urandom_range(3, 0);
		bx = $urandom_range(C_MAX, 0);
		by = $urandom_range(C_MAX, 0);
		bz = $urandom_range(C_MAX, 0);
		for (int k = 0; k < n; k++)
			send(pick_coord(style, bx), pick_coord(style, by), pick_coord(style, bz), k == n - 1);
	endtask

	function automatic int set_size();
		int r;
		r = $urandom_range(99, 0);
		if (r < 5) return 1;
		if (r < 95) return $urandom_range(8, 2);
		return $urandom_range(20, 9);
	endfunction

	function automatic logic [COORD_W-1:0] pick_reg(int w, logic [COORD_W-1:0] dflt, int lo);
		logic [COORD_W-1:0] top_v;
		top_v = (1 << w) - 1;
		case ($urandom_range(4, 0))
			0: return lo;
			1: return top_v;
			2: return dflt;
			3: return dflt + $urandom_range(dflt, 0) - (dflt >> 1);
			default: return $urandom_range(top_v, lo);
		endcase
	endfunction

	initial begin
		int phase;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		send(0, 0, 0, 0);
		send(C_MAX, C_MAX, C_MAX, 1);
		send(12345, 54321, 777, 1);
		send(100000, 100000, 100000, 0);
		send(100000, 100000, 100000, 1);
		send(200000, 200000, 200000, 0);
		send(200001, 200000, 200000, 1);
		send(0, 0, 0, 0);
		send(327680, 0, 0, 0);
		send(0, 327680, 0, 0);
		send(0, 0, 327680, 1);
		send(0, 0, 0, 0);
		send(BOX_DEF - 1, 0, 0, 0);
		send(BOX_DEF >> 1, BOX_DEF >> 1, 0, 1);
		settle();
		write_reg(CFG_EPS, 0);
		send(5000, 5000, 5000, 0);
		send(5001, 5000, 5000, 1);
		settle();
		write_reg(CFG_EPS, (1 << SIG_W) - 1);
		write_reg(CFG_SIGMA, (1 << SIG_W) - 1);
		write_reg(CFG_BOX_X, 1);
		write_reg(CFG_BOX_Y, C_MAX);
		write_reg(CFG_BOX_Z, C_MAX);
		send(C_MAX, 0, C_MAX, 0);
		send(0, C_MAX, 1, 0);
		send(2097152, 2097151, 4000000, 1);
		settle();

		write_reg(CFG_BOX_X, BOX_DEF);
		write_reg(CFG_SIGMA, 237503);
		write_reg(CFG_EPS, 20775);
		cur_box = BOX_DEF;
		for (int k = 0; k < 34; k++)
			send($urandom_range(C_MAX, 0), $urandom_range(C_MAX, 0), $urandom_range(C_MAX, 0),
				k == 33);
		random_set(32);

		phase = 0;
		while (n_sent < 1050) begin
			settle();
			if (phase > 0) begin
				cur_box = pick_reg(COORD_W, BOX_DEF, 1);
				write_reg(CFG_BOX_X, cur_box);
				write_reg(CFG_BOX_Y, pick_reg(COORD_W, BOX_DEF, 1));
				write_reg(CFG_BOX_Z, pick_reg(COORD_W, BOX_DEF, 1));
				write_reg(CFG_SIGMA, pick_reg(SIG_W, 237503, 0));
				write_reg(CFG_EPS, pick_reg(SIG_W, 20775, 0));
			end
			if (phase == 1) begin
				hold_req = 1;
				repeat (4) random_set(3);
			end
			repeat (10) random_set(set_size());
			phase++;
		end

		settle();
		repeat (200) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("lennard_jones_pair_energy_test: done, clean");
		else
			$display("lennard_jones_pair_energy_test: done, errors");
		$finish;
	end
endmodule

FILE: sim.f
rtl/ljpe_pkg.sv
rtl/ljpe_front.sv
rtl/ljpe_cmd_fifo.sv
rtl/ljpe_back.sv
rtl/lennard_jones_pair_energy.sv
tb/sv/ljpe_energy_checker.sv
tb/sv/lennard_jones_pair_energy_test.sv
